FILE: src/pbrs_pkg.sv
// Package for the periodic burst record scheduler.
// Holds sizes, register indexes, the idle stop code and the shared types.
// No dependencies.
`timescale 1ns / 1ps

package pbrs_pkg;

  localparam int CHANNELS    = 4;
  localparam int OFFSET_BITS = 32;
  localparam int MAX_OUT     = 4;
  localparam int NUM_SETUP   = 4;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int N_LIMIT     = (CHANNELS < MAX_OUT) ? CHANNELS : MAX_OUT;
  localparam int FIFO_DEPTH  = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_BASE      = 3'd1;

  localparam logic [11:0] IDLE_STOP = 12'hFFF;

  typedef struct packed {
    logic [2:0]                  count;
    logic [CHANNELS-1:0][63:0]   setup;
  } pbrs_cfg_t;

  typedef struct packed {
    logic                        restart;
    logic [31:0]                 step;
    logic [CHANNELS-1:0]         mask;
    logic [CHANNELS-1:0][7:0]    sizes;
  } pbrs_entry_t;

endpackage

FILE: src/pbrs_front.sv
// Front end of the scheduler: accepts ticks and advances every channel.
// Pushes one classified entry per tick into the queue. Uses pbrs_pkg.
`timescale 1ns / 1ps

module pbrs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbrs_pkg::pbrs_cfg_t cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_restart_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output pbrs_pkg::pbrs_entry_t push_entry_o
);

  logic [31:0] step_q, step_d;
  logic [pbrs_pkg::CHANNELS-1:0][15:0] dly_q, dly_d;
  logic [pbrs_pkg::CHANNELS-1:0][15:0] phase_q, phase_d;
  logic [pbrs_pkg::CHANNELS-1:0][11:0] bidx_q, bidx_d;
  logic [pbrs_pkg::CHANNELS-1:0][11:0] idle_q, idle_d;
  logic [pbrs_pkg::CHANNELS-1:0]       stop_q, stop_d;
  logic [pbrs_pkg::CHANNELS-1:0]       wr;
  logic [2:0]  n_lim;
  logic [31:0] stp;
  logic        accept;

  assign accept       = in_valid_i && in_ready_o;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign stp          = in_restart_i ? 32'd0 : step_q;
  assign step_d       = stp + 32'd1;
  assign n_lim        = (cfg_i.count > 3'(pbrs_pkg::N_LIMIT)) ? 3'(pbrs_pkg::N_LIMIT)
                                                               : cfg_i.count;

  always_comb begin
    logic [15:0] per;
    logic [11:0] burst;
    logic [11:0] idle;
    logic [15:0] dly;
    logic [15:0] ph;
    logic [11:0] bi;
    logic [11:0] il;
    logic        st;
    logic [11:0] bi_inc;
    logic [16:0] ph_inc;
    for (int c = 0; c < pbrs_pkg::CHANNELS; c++) begin
      per   = (cfg_i.setup[c][31:16] == 16'd0) ? 16'd1 : cfg_i.setup[c][31:16];
      burst = cfg_i.setup[c][43:32];
      idle  = cfg_i.setup[c][55:44];
      if (in_restart_i) begin
        dly = cfg_i.setup[c][15:0];
        ph  = '0;
        bi  = '0;
        il  = '0;
        st  = 1'b0;
      end else begin
        dly = dly_q[c];
        ph  = phase_q[c];
        bi  = bidx_q[c];
        il  = idle_q[c];
        st  = stop_q[c];
      end
      bi_inc = bi + 12'd1;
      ph_inc = {1'b0, ph} + 17'd1;
      wr[c]  = 1'b0;
      if (st) begin
      end else if (dly != 16'd0) begin
        dly = dly - 16'd1;
      end else if (il != 12'd0) begin
        il = il - 12'd1;
      end else if (ph == 16'd0) begin
        wr[c] = 1'b1;
        if (burst != 12'd0 && bi_inc >= burst) begin
          bi = '0;
          ph = '0;
          if (idle == pbrs_pkg::IDLE_STOP) begin
            st = 1'b1;
          end else begin
            il = idle;
          end
        end else begin
          bi = bi_inc;
          ph = (per > 16'd1) ? 16'd1 : 16'd0;
        end
      end else begin
        ph = (ph_inc >= {1'b0, per}) ? 16'd0 : ph_inc[15:0];
      end
      dly_d[c]   = dly;
      phase_d[c] = ph;
      bidx_d[c]  = bi;
      idle_d[c]  = il;
      stop_d[c]  = st;
      push_entry_o.mask[c]  = wr[c] && (c < int'(n_lim));
      push_entry_o.sizes[c] = cfg_i.setup[c][63:56];
    end
    push_entry_o.restart = in_restart_i;
    push_entry_o.step    = stp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      dly_q   <= '0;
      phase_q <= '0;
      bidx_q  <= '0;
      idle_q  <= '0;
      stop_q  <= '0;
    end else if (accept) begin
      step_q  <= step_d;
      dly_q   <= dly_d;
      phase_q <= phase_d;
      bidx_q  <= bidx_d;
      idle_q  <= idle_d;
      stop_q  <= stop_d;
    end
  end

endmodule

FILE: src/pbrs_fifo.sv
// Short queue of tick entries between the front end and the back end.
// Two entries with valid and ready on both sides. Uses pbrs_pkg.
`timescale 1ns / 1ps

module pbrs_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  pbrs_pkg::pbrs_entry_t push_entry_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output pbrs_pkg::pbrs_entry_t pop_entry_o
);

  localparam int PTR_W = (pbrs_pkg::FIFO_DEPTH > 1) ? $clog2(pbrs_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(pbrs_pkg::FIFO_DEPTH + 1);

  pbrs_pkg::pbrs_entry_t mem_q [pbrs_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic push;
  logic pop;

  assign push_ready_o = (count_q != CNT_W'(pbrs_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(pbrs_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(pbrs_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(pbrs_pkg::FIFO_DEPTH))
    else $error("Queue count exceeds its depth.");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("Queue count did not grow on a lone push.");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("Queue count did not shrink on a lone pop.");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("Queue pointers differ while the queue is empty.");
`endif

endmodule

FILE: src/pbrs_back.sv
// Back end of the scheduler: expands each tick entry into its results.
// Keeps the running data offset and the output register. Uses pbrs_pkg.
`timescale 1ns / 1ps

module pbrs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  pbrs_pkg::pbrs_entry_t pop_entry_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_has_write_o,
  output logic [1:0]            out_channel_o,
  output logic [31:0]           out_data_offset_o,
  output logic [7:0]            out_record_size_o,
  output logic [31:0]           out_step_number_o,
  output logic                  out_last_o
);

  logic                               cur_valid_q, cur_valid_d;
  logic [pbrs_pkg::CHANNELS-1:0]      cur_mask_q, cur_mask_d;
  logic [31:0]                        cur_step_q;
  logic [pbrs_pkg::CHANNELS-1:0][7:0] cur_sizes_q;
  logic [pbrs_pkg::OFFSET_BITS-1:0]   offset_q, offset_d;
  logic                               out_valid_q, out_valid_d;
  logic                               has_write_q;
  logic [1:0]                         channel_q;
  logic [31:0]                        data_offset_q;
  logic [7:0]                         record_size_q;
  logic [31:0]                        step_number_q;
  logic                               last_q;
  logic [pbrs_pkg::CH_W-1:0]          sel_idx;
  logic                               sel_found;
  logic [pbrs_pkg::CHANNELS-1:0]      mask_clr;
  logic                               is_last;
  logic                               emit;
  logic                               load;

  always_comb begin
    sel_idx   = '0;
    sel_found = 1'b0;
    for (int c = pbrs_pkg::CHANNELS - 1; c >= 0; c--) begin
      if (cur_mask_q[c]) begin
        sel_idx   = pbrs_pkg::CH_W'(c);
        sel_found = 1'b1;
      end
    end
    mask_clr = cur_mask_q;
    if (sel_found) begin
      mask_clr[sel_idx] = 1'b0;
    end
  end

  assign is_last     = (mask_clr == '0);
  assign emit        = cur_valid_q && (!out_valid_q || out_ready_i);
  assign load        = pop_valid_i && (!cur_valid_q || (emit && is_last));
  assign pop_ready_o = !cur_valid_q || (emit && is_last);

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_mask_d  = cur_mask_q;
    offset_d    = offset_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      cur_mask_d  = mask_clr;
      out_valid_d = 1'b1;
      if (is_last) begin
        cur_valid_d = 1'b0;
      end
      if (sel_found) begin
        offset_d = offset_q
                 + pbrs_pkg::OFFSET_BITS'(cur_sizes_q[sel_idx]);
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      cur_valid_d = 1'b1;
      cur_mask_d  = pop_entry_i.mask;
      if (pop_entry_i.restart) begin
        offset_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cur_mask_q  <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      cur_mask_q  <= cur_mask_d;
      offset_q    <= offset_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_step_q  <= pop_entry_i.step;
      cur_sizes_q <= pop_entry_i.sizes;
    end
    if (emit) begin
      has_write_q   <= sel_found;
      channel_q     <= sel_found ? 2'(sel_idx) : 2'd0;
      data_offset_q <= sel_found ? 32'(offset_q) : 32'd0;
      record_size_q <= sel_found ? cur_sizes_q[sel_idx] : 8'd0;
      step_number_q <= cur_step_q;
      last_q        <= is_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_has_write_o   = has_write_q;
  assign out_channel_o     = channel_q;
  assign out_data_offset_o = data_offset_q;
  assign out_record_size_o = record_size_q;
  assign out_step_number_o = step_number_q;
  assign out_last_o        = last_q;

endmodule

FILE: src/periodic_burst_record_scheduler.sv
// Top level of the periodic burst record scheduler: configuration registers
// and the front end, queue and back end. Uses pbrs_pkg and the pbrs modules.
//
// Each accepted tick advances every channel's delay, idle, period and burst
// counters in the front end and is queued as one entry; the back end then
// gives one result per cycle from its output register while the output is
// not stalled, so a tick yields max(1, k) results, where k is the number of channels
// in use that record at that step (at most four). A new tick is accepted every
// cycle while the two-entry queue between front and back has room.
`timescale 1ns / 1ps

module periodic_burst_record_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_has_write_o,
  output logic [1:0]  out_channel_o,
  output logic [31:0] out_data_offset_o,
  output logic [7:0]  out_record_size_o,
  output logic [31:0] out_step_number_o,
  output logic        out_last_o
);

  pbrs_pkg::pbrs_cfg_t   cfg_q;
  logic                  push_valid;
  logic                  push_ready;
  pbrs_pkg::pbrs_entry_t push_entry;
  logic                  pop_valid;
  logic                  pop_ready;
  pbrs_pkg::pbrs_entry_t pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pbrs_pkg::REG_CHANNELS_IN_USE) begin
        cfg_q.count <= cfg_data_i[2:0];
      end
      for (int c = 0; c < pbrs_pkg::CHANNELS; c++) begin
        if (c < pbrs_pkg::NUM_SETUP
            && cfg_idx_i == pbrs_pkg::CFG_IDX_W'(int'(pbrs_pkg::REG_SETUP_BASE) + c)) begin
          cfg_q.setup[c] <= cfg_data_i;
        end
      end
    end
  end

  pbrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_restart_i (in_restart_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  pbrs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  pbrs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_entry_i       (pop_entry),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_has_write_o   (out_has_write_o),
    .out_channel_o     (out_channel_o),
    .out_data_offset_o (out_data_offset_o),
    .out_record_size_o (out_record_size_o),
    .out_step_number_o (out_step_number_o),
    .out_last_o        (out_last_o)
  );

endmodule

FILE: test/tb_periodic_burst_record_scheduler.sv
// Testbench for periodic_burst_record_scheduler: drives ticks and register writes and
// checks every result against a cycle-free model of the channel schedule.
// Depends on pbrs_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_periodic_burst_record_scheduler;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_TICKS = 270;
  localparam logic [pbrs_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED =
    pbrs_pkg::REG_SETUP_BASE + pbrs_pkg::CFG_IDX_W'(pbrs_pkg::NUM_SETUP);
  localparam int REG_LAST_INDEX = (1 << pbrs_pkg::CFG_IDX_W) - 1;

  typedef struct packed {
    logic        has_write;
    logic [1:0]  channel;
    logic [31:0] data_offset;
    logic [7:0]  record_size;
    logic [31:0] step_number;
    logic        last;
  } sched_rec_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        in_restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        out_has_write_o;
  logic [1:0]  out_channel_o;
  logic [31:0] out_data_offset_o;
  logic [7:0]  out_record_size_o;
  logic [31:0] out_step_number_o;
  logic        out_last_o;

  periodic_burst_record_scheduler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_restart_i      (in_restart_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_has_write_o   (out_has_write_o),
    .out_channel_o     (out_channel_o),
    .out_data_offset_o (out_data_offset_o),
    .out_record_size_o (out_record_size_o),
    .out_step_number_o (out_step_number_o),
    .out_last_o        (out_last_o)
  );

  logic [2:0]  cfg_count = '0;
  logic [63:0] cfg_setup [pbrs_pkg::CHANNELS];
  logic [31:0] step_now = '0;
  logic [31:0] offset_sum = '0;
  logic [15:0] delay_cnt [pbrs_pkg::CHANNELS];
  logic [15:0] phase_cnt [pbrs_pkg::CHANNELS];
  logic [11:0] burst_cnt [pbrs_pkg::CHANNELS];
  logic [11:0] idle_cnt [pbrs_pkg::CHANNELS];
  logic        halted [pbrs_pkg::CHANNELS];

  sched_rec_t  expected_records [$];
  logic        pending_ticks [$];
  sched_rec_t  got_rec;
  sched_rec_t  want_rec;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_cycle = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int          quiet_cycles = 0;
  int          mismatch_count = 0;
  int          ticks_sent = 0;
  int          restarts_sent = 0;
  int          results_seen = 0;
  int          records_seen = 0;
  int          phase_count = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] pack_setup(logic [15:0] delay, logic [15:0] period,
                                             logic [11:0] burst, logic [11:0] idle,
                                             logic [7:0] size);
    return {size, idle, burst, period, delay};
  endfunction

  function automatic logic channel_records(int c);
    logic [15:0] period;
    logic [11:0] burst;
    logic [11:0] idle;
    logic [16:0] next_phase;
    period = cfg_setup[c][31:16];
    burst  = cfg_setup[c][43:32];
    idle   = cfg_setup[c][55:44];
    if (period == 16'd0) period = 16'd1;
    if (halted[c]) return 1'b0;
    if (delay_cnt[c] != 16'd0) begin
      delay_cnt[c] = delay_cnt[c] - 16'd1;
      return 1'b0;
    end
    if (idle_cnt[c] != 12'd0) begin
      idle_cnt[c] = idle_cnt[c] - 12'd1;
      return 1'b0;
    end
    if (phase_cnt[c] == 16'd0) begin
      burst_cnt[c] = burst_cnt[c] + 12'd1;
      if (burst != 12'd0 && burst_cnt[c] >= burst) begin
        burst_cnt[c] = '0;
        phase_cnt[c] = '0;
        if (idle == pbrs_pkg::IDLE_STOP) halted[c] = 1'b1;
        else idle_cnt[c] = idle;
      end else begin
        phase_cnt[c] = (period > 16'd1) ? 16'd1 : 16'd0;
      end
      return 1'b1;
    end
    next_phase = {1'b0, phase_cnt[c]} + 17'd1;
    if (next_phase >= {1'b0, period}) next_phase = '0;
    phase_cnt[c] = next_phase[15:0];
    return 1'b0;
  endfunction

  function automatic void schedule_tick(logic restart);
    int         active;
    int         produced;
    int         c;
    logic       fires;
    sched_rec_t recs [pbrs_pkg::MAX_OUT];
    active = (int'(cfg_count) > pbrs_pkg::N_LIMIT) ? pbrs_pkg::N_LIMIT : int'(cfg_count);
    if (restart) begin
      step_now = '0;
      offset_sum = '0;
      for (c = 0; c < pbrs_pkg::CHANNELS; c++) begin
        delay_cnt[c] = cfg_setup[c][15:0];
        phase_cnt[c] = '0;
        burst_cnt[c] = '0;
        idle_cnt[c]  = '0;
        halted[c]    = 1'b0;
      end
    end
    produced = 0;
    for (c = 0; c < pbrs_pkg::CHANNELS; c++) begin
      fires = channel_records(c);
      if (fires && c < active) begin
        recs[produced] = '{1'b1, 2'(c), offset_sum, cfg_setup[c][63:56], step_now, 1'b0};
        offset_sum = offset_sum + 32'(cfg_setup[c][63:56]);
        produced++;
      end
    end
    if (produced == 0) begin
      expected_records.push_back('{1'b0, 2'd0, 32'd0, 8'd0, step_now, 1'b1});
    end else begin
      recs[produced-1].last = 1'b1;
      for (c = 0; c < produced; c++) expected_records.push_back(recs[c]);
    end
    step_now = step_now + 32'd1;
    ticks_sent++;
    if (restart) restarts_sent++;
  endfunction

  task automatic write_register(logic [2:0] idx, logic [63:0] data);
    if (idx == pbrs_pkg::REG_CHANNELS_IN_USE) begin
      cfg_count = data[2:0];
    end else if (idx >= pbrs_pkg::REG_SETUP_BASE
                 && int'(idx) < int'(pbrs_pkg::REG_SETUP_BASE) + pbrs_pkg::NUM_SETUP) begin
      cfg_setup[idx - pbrs_pkg::REG_SETUP_BASE] = data;
    end
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid_i || expected_records.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (6) @(negedge clk_i);
    phase_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      in_restart_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) schedule_tick(in_restart_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          in_valid_i   <= 1'b1;
          in_restart_i <= pending_ticks.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 64 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 2));
      case (rx_mode)
        RX_ALWAYS:  out_ready_i <= 1'b1;
        RX_RANDOM:  out_ready_i <= ($urandom_range(0, 9) < 7);
        default:    out_ready_i <= (stall_cycle % 8 < 5);
      endcase
      if (out_valid_o && out_ready_i) begin
        got_rec = {out_has_write_o, out_channel_o, out_data_offset_o, out_record_size_o,
                   out_step_number_o, out_last_o};
        results_seen++;
        if (out_has_write_o) records_seen++;
        if (expected_records.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected: has_write=%0b ch=%0d offset=%0h size=%0d step=%0d last=%0b",
                     got_rec.has_write, got_rec.channel, got_rec.data_offset,
                     got_rec.record_size, got_rec.step_number, got_rec.last);
          end
        end else begin
          want_rec = expected_records.pop_front();
          if (got_rec !== want_rec) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Expected: has_write=%0b ch=%0d offset=%0h size=%0d step=%0d last=%0b",
                       want_rec.has_write, want_rec.channel, want_rec.data_offset,
                       want_rec.record_size, want_rec.step_number, want_rec.last);
              $display("Actual:   has_write=%0b ch=%0d offset=%0h size=%0d step=%0d last=%0b",
                       got_rec.has_write, got_rec.channel, got_rec.data_offset,
                       got_rec.record_size, got_rec.step_number, got_rec.last);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transfer.", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int          len;
    int          random_ticks;
    int          c;
    int          k;
    logic [63:0] setup_word;
    for (c = 0; c < pbrs_pkg::CHANNELS; c++) begin
      cfg_setup[c] = '0;
      delay_cnt[c] = '0;
      phase_cnt[c] = '0;
      burst_cnt[c] = '0;
      idle_cnt[c]  = '0;
      halted[c]    = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: no channel in use, so every tick is a no-write result.
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    pending_ticks.push_back(1'b0);
    wait_drained();

    // Four channels with period zero, burst stop, idle gaps and zero size.
    write_register(pbrs_pkg::REG_CHANNELS_IN_USE, 64'd4);
    write_register(pbrs_pkg::REG_SETUP_BASE + 3'd0,
                   pack_setup(16'd0, 16'd0, 12'd0, 12'd0, 8'hFF));
    write_register(pbrs_pkg::REG_SETUP_BASE + 3'd1,
                   pack_setup(16'd3, 16'd1, 12'd2, 12'd1, 8'd1));
    write_register(pbrs_pkg::REG_SETUP_BASE + 3'd2,
                   pack_setup(16'd2, 16'd3, 12'd1, pbrs_pkg::IDLE_STOP, 8'h80));
    write_register(pbrs_pkg::REG_SETUP_BASE + 3'd3,
                   pack_setup(16'd1, 16'd2, 12'd3, 12'd0, 8'd0));
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    repeat (7) pending_ticks.push_back(1'b0);
    wait_drained();

    // All-ones setup, a saturated channel count, ignored indexes and a period change.
    write_register(pbrs_pkg::REG_CHANNELS_IN_USE, 64'd7);
    write_register(pbrs_pkg::REG_SETUP_BASE + 3'd0, '1);
    write_register(pbrs_pkg::REG_SETUP_BASE + 3'd3,
                   pack_setup(16'd0, 16'd1, 12'd0, 12'd0, 8'd5));
    for (k = int'(REG_FIRST_UNUSED); k <= REG_LAST_INDEX; k++) begin
      write_register(3'(k), {$urandom, $urandom});
    end
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    wait_drained();

    write_register(pbrs_pkg::REG_CHANNELS_IN_USE, 64'd2);
    repeat (3) pending_ticks.push_back(1'b0);
    wait_drained();

    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      if ($urandom_range(0, 3) != 0) begin
        write_register(pbrs_pkg::REG_CHANNELS_IN_USE, 64'($urandom_range(3, 4)));
      end else begin
        write_register(pbrs_pkg::REG_CHANNELS_IN_USE, {$urandom, $urandom});
      end
      for (c = 0; c < pbrs_pkg::NUM_SETUP; c++) begin
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 7) == 0) begin
            setup_word = {$urandom, $urandom};
          end else begin
            setup_word = pack_setup(16'($urandom_range(0, 5)), 16'($urandom_range(0, 6)),
                                    12'($urandom_range(0, 5)),
                                    ($urandom_range(0, 3) == 0) ? pbrs_pkg::IDLE_STOP
                                                                : 12'($urandom_range(0, 4)),
                                    8'($urandom));
          end
          write_register(pbrs_pkg::REG_SETUP_BASE + 3'(c), setup_word);
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        write_register(3'($urandom_range(int'(REG_FIRST_UNUSED), REG_LAST_INDEX)),
                       {$urandom, $urandom});
      end
      len = $urandom_range(15, 40);
      pending_ticks.push_back($urandom_range(0, 7) != 0);
      for (k = 1; k < len; k++) pending_ticks.push_back($urandom_range(0, 19) == 0);
      random_ticks += len;
      wait_drained();
    end

    repeat (12) @(negedge clk_i);
    if (expected_records.size() != 0) mismatch_count += expected_records.size();
    $display("Sent %0d ticks (%0d restarts) over %0d setting phases.",
             ticks_sent, restarts_sent, phase_count);
    $display("Checked %0d results, %0d of them channel records.", results_seen, records_seen);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/pbrs_pkg.sv
src/pbrs_front.sv
src/pbrs_fifo.sv
src/pbrs_back.sv
src/periodic_burst_record_scheduler.sv
test/tb_periodic_burst_record_scheduler.sv
